// ----- sv/cpt_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the closest-point-on-triangle pipeline.
// No dependencies.
package cpt_pkg;

  // operand B of the pipelined multiplier is consumed this many bits per stage
  localparam int MUL_CHUNK = 16;

  typedef logic [2:0] region_t;

  localparam region_t RGN_VERT_A  = 3'd0;
  localparam region_t RGN_VERT_B  = 3'd1;
  localparam region_t RGN_VERT_C  = 3'd2;
  localparam region_t RGN_EDGE_AB = 3'd3;
  localparam region_t RGN_EDGE_BC = 3'd4;
  localparam region_t RGN_EDGE_CA = 3'd5;
  localparam region_t RGN_FACE    = 3'd6;

endpackage

// ----- sv/cpt_mul.sv -----
`timescale 1ns / 1ps
// Pipelined signed multiplier: one MUL_CHUNK-bit digit of b per stage.
// Depends on cpt_pkg. One product per cycle.
module cpt_mul #(
  parameter int AW = 33,
  parameter int BW = 33
) (
  input  logic                    clk,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0] p
);

  localparam int CH  = cpt_pkg::MUL_CHUNK;
  localparam int NC  = (BW + CH - 1) / CH;
  localparam int BPW = NC * CH;
  localparam int PW  = AW + BW;

  logic signed [BPW-1:0] b_ext;
  logic signed [AW-1:0]  a_q [NC-1];
  logic signed [BPW-1:0] b_q [NC-1];
  logic signed [PW-1:0]  acc [NC];

  assign b_ext = BPW'(b);

  for (genvar k = 0; k < NC; k++) begin : g_st
    logic signed [AW-1:0]  a_s;
    logic signed [BPW-1:0] b_s;
    logic signed [CH:0]    dig;
    logic signed [AW+CH:0] pp;
    logic signed [PW-1:0]  pps;

    if (k == 0) begin : g_src0
      assign a_s = a;
      assign b_s = b_ext;
    end else begin : g_srcn
      assign a_s = a_q[k-1];
      assign b_s = b_q[k-1];
    end

    // only the top digit carries the sign
    if (k == NC - 1) begin : g_top
      assign dig = {b_s[BPW-1], b_s[k*CH +: CH]};
    end else begin : g_low
      assign dig = {1'b0, b_s[k*CH +: CH]};
    end

    assign pp  = a_s * dig;
    assign pps = PW'(pp) <<< (k * CH);

    if (k == 0) begin : g_acc0
      always_ff @(posedge clk) begin
        acc[0] <= pps;
      end
    end else begin : g_accn
      always_ff @(posedge clk) begin
        acc[k] <= acc[k-1] + pps;
      end
    end

    if (k < NC - 1) begin : g_fwd
      always_ff @(posedge clk) begin
        a_q[k] <= a_s;
        b_q[k] <= b_s;
      end
    end
  end

  assign p = acc[NC-1];

endmodule

// ----- sv/cpt_div.sv -----
`timescale 1ns / 1ps
// Pipelined restoring divider, rounds to nearest with ties away from zero.
// Quotient magnitude clamps to 2^QB. No dependencies.
module cpt_div #(
  parameter int NW = 171,
  parameter int QB = 33
) (
  input  logic                 clk,
  input  logic signed [NW-1:0] num,
  input  logic signed [NW-1:0] den,
  output logic signed [QB+1:0] q
);

  localparam int OW = QB + 2;
  localparam int RW = NW + QB + 2;
  localparam int DW = NW + 1;

  logic [RW-1:0] rem_a [QB+1];
  logic [DW-1:0] d_a   [QB+1];
  logic [QB-1:0] q_a   [QB+1];
  logic          neg_a [QB+1];
  logic          ovf_a [QB+1];

  logic [NW-1:0] mag;
  logic [RW-1:0] m0;
  logic [RW-1:0] d0;
  logic [QB:0]   qm;

  // magnitude numerator 2|n| + d over divisor 2d
  assign mag = num[NW-1] ? NW'(-num) : NW'(num);
  assign m0  = (RW'(mag) << 1) + RW'($unsigned(den));
  assign d0  = RW'($unsigned(den)) << 1;

  always_ff @(posedge clk) begin
    rem_a[0] <= m0;
    d_a[0]   <= d0[DW-1:0];
    q_a[0]   <= '0;
    neg_a[0] <= num[NW-1];
    ovf_a[0] <= m0 >= (d0 << QB);
  end

  for (genvar j = 0; j < QB; j++) begin : g_step
    localparam int K = QB - 1 - j;
    logic [RW-1:0] sh;
    logic          ge;
    logic [QB-1:0] q_next;

    assign sh = RW'(d_a[j]) << K;
    assign ge = rem_a[j] >= sh;

    always_comb begin
      q_next    = q_a[j];
      q_next[K] = ge;
    end

    always_ff @(posedge clk) begin
      rem_a[j+1] <= ge ? rem_a[j] - sh : rem_a[j];
      d_a[j+1]   <= d_a[j];
      q_a[j+1]   <= q_next;
      neg_a[j+1] <= neg_a[j];
      ovf_a[j+1] <= ovf_a[j];
    end
  end

  assign qm = ovf_a[QB] ? ((QB+1)'(1) << QB) : {1'b0, q_a[QB]};
  assign q  = neg_a[QB] ? -$signed(OW'(qm)) : $signed(OW'(qm));

endmodule

// ----- sv/closest_point_on_triangle_top.sv -----
`timescale 1ns / 1ps
// Closest point on a triangle to a query point, fully pipelined.
// Depends on cpt_pkg, cpt_mul and cpt_div.
//
// Usage: drive the three vertices and the query point and pulse start; a beat
// is taken at every rising edge with start high and busy low. busy is always
// low: the pipeline never stalls, so one beat may enter every cycle.
// Each result is presented for exactly one cycle with done high, together
// with near_x/y/z, region and degenerate; results leave in input order.
// Throughput is one beat per cycle. The depth is set by the 16-bit-per-stage
// multipliers (three levels) and the one-bit-per-stage rounding divider, whose
// W+1 quotient bits are enough once the result is saturated.
// rst (synchronous) drops every beat in flight; nothing else is cleared.
// The receiver cannot stall: a result not taken when done is high is lost.
module closest_point_on_triangle_top #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] vert_a_x,
  input  logic signed [COORD_WIDTH-1:0] vert_a_y,
  input  logic signed [COORD_WIDTH-1:0] vert_a_z,
  input  logic signed [COORD_WIDTH-1:0] vert_b_x,
  input  logic signed [COORD_WIDTH-1:0] vert_b_y,
  input  logic signed [COORD_WIDTH-1:0] vert_b_z,
  input  logic signed [COORD_WIDTH-1:0] vert_c_x,
  input  logic signed [COORD_WIDTH-1:0] vert_c_y,
  input  logic signed [COORD_WIDTH-1:0] vert_c_z,
  input  logic signed [COORD_WIDTH-1:0] query_x,
  input  logic signed [COORD_WIDTH-1:0] query_y,
  input  logic signed [COORD_WIDTH-1:0] query_z,
  output logic                          done,
  output logic signed [COORD_WIDTH-1:0] near_x,
  output logic signed [COORD_WIDTH-1:0] near_y,
  output logic signed [COORD_WIDTH-1:0] near_z,
  output cpt_pkg::region_t              region,
  output logic                          degenerate
);

  localparam int W    = COORD_WIDTH;
  localparam int DFW  = W + 1;
  localparam int P1W  = 2 * DFW;
  localparam int DOTW = 2 * W + 4;
  localparam int CRW  = 2 * W + 3;
  localparam int P2W  = 2 * CRW;
  localparam int VW   = 4 * W + 8;
  localparam int P3W  = VW + DFW;
  localparam int NW   = 5 * W + 11;
  localparam int QB   = W + 1;
  localparam int OW   = QB + 2;
  localparam int CH   = cpt_pkg::MUL_CHUNK;
  localparam int L1   = (DFW + CH - 1) / CH;
  localparam int L2   = (CRW + CH - 1) / CH;
  localparam int L3   = (VW + CH - 1) / CH;
  localparam int LD   = QB + 1;
  localparam int S6   = L1 + L2 + L3 + LD + 6;
  localparam int LAT  = S6 + 1;
  localparam int SW   = NW + 6 * W + 4;
  localparam int S2W  = 6 * W + 4;

  // difference vectors: 0 ab, 1 ac, 2 bc, 3 ap, 4 bp, 5 cp (ap = a - p)
  localparam int DOT_X [6] = '{3, 4, 3, 5, 4, 5};
  localparam int DOT_Y [6] = '{0, 0, 1, 1, 2, 2};
  localparam logic [5:0] DOT_NEG = 6'b010101;
  // crosses: n = ab x ac, then ap x bp, bp x cp, cp x ap
  localparam int CRS_X [4] = '{0, 3, 4, 5};
  localparam int CRS_Y [4] = '{1, 4, 5, 3};

  logic [S6:0] vld;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[S6-1:0], start};
    end
  end

  // ---- s0: input registers
  logic signed [W-1:0] pt0 [4][3];

  always_ff @(posedge clk) begin
    pt0[0][0] <= vert_a_x; pt0[0][1] <= vert_a_y; pt0[0][2] <= vert_a_z;
    pt0[1][0] <= vert_b_x; pt0[1][1] <= vert_b_y; pt0[1][2] <= vert_b_z;
    pt0[2][0] <= vert_c_x; pt0[2][1] <= vert_c_y; pt0[2][2] <= vert_c_z;
    pt0[3][0] <= query_x;  pt0[3][1] <= query_y;  pt0[3][2] <= query_z;
  end

  // ---- s1: differences
  logic signed [DFW-1:0] dv1 [6][3];
  logic [9*W-1:0]        vtx1;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      dv1[0][i] <= DFW'(pt0[1][i]) - DFW'(pt0[0][i]);
      dv1[1][i] <= DFW'(pt0[2][i]) - DFW'(pt0[0][i]);
      dv1[2][i] <= DFW'(pt0[2][i]) - DFW'(pt0[1][i]);
      dv1[3][i] <= DFW'(pt0[0][i]) - DFW'(pt0[3][i]);
      dv1[4][i] <= DFW'(pt0[1][i]) - DFW'(pt0[3][i]);
      dv1[5][i] <= DFW'(pt0[2][i]) - DFW'(pt0[3][i]);
      for (int v = 0; v < 3; v++) begin
        vtx1[(v*3+i)*W +: W] <= pt0[v][i];
      end
    end
  end

  // ---- mul level 1: 18 dot terms, 24 cross terms
  logic signed [DFW-1:0] m1x [42];
  logic signed [DFW-1:0] m1y [42];
  logic signed [P1W-1:0] m1p [42];

  for (genvar g = 0; g < 18; g++) begin : g_m1d
    assign m1x[g] = dv1[DOT_X[g/3]][g%3];
    assign m1y[g] = dv1[DOT_Y[g/3]][g%3];
  end

  for (genvar g = 0; g < 24; g++) begin : g_m1c
    localparam int C  = g / 6;
    localparam int J  = (g % 6) / 2;
    localparam int XI = (g % 2 == 0) ? (J + 1) % 3 : (J + 2) % 3;
    localparam int YI = (g % 2 == 0) ? (J + 2) % 3 : (J + 1) % 3;
    assign m1x[18+g] = dv1[CRS_X[C]][XI];
    assign m1y[18+g] = dv1[CRS_Y[C]][YI];
  end

  for (genvar g = 0; g < 42; g++) begin : g_mul1
    cpt_mul #(.AW(DFW), .BW(DFW)) u_mul (
      .clk (clk),
      .a   (m1x[g]),
      .b   (m1y[g]),
      .p   (m1p[g])
    );
  end

  // ---- s2: dot products and cross components
  logic signed [DOTW-1:0] dsum [6];
  logic signed [DOTW-1:0] dot2 [6];
  logic signed [CRW-1:0]  cr2  [4][3];

  always_comb begin
    for (int d = 0; d < 6; d++) begin
      dsum[d] = DOTW'(m1p[d*3]) + DOTW'(m1p[d*3+1]) + DOTW'(m1p[d*3+2]);
    end
  end

  always_ff @(posedge clk) begin
    for (int d = 0; d < 6; d++) begin
      dot2[d] <= DOT_NEG[d] ? -dsum[d] : dsum[d];
    end
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 3; j++) begin
        cr2[c][j] <= CRW'(m1p[18+c*6+j*2]) - CRW'(m1p[18+c*6+j*2+1]);
      end
    end
  end

  // ---- mul level 2: n . (ap x bp), n . (bp x cp), n . (cp x ap)
  logic signed [P2W-1:0] m2p [9];

  for (genvar g = 0; g < 9; g++) begin : g_mul2
    cpt_mul #(.AW(CRW), .BW(CRW)) u_mul (
      .clk (clk),
      .a   (cr2[0][g%3]),
      .b   (cr2[g/3+1][g%3]),
      .p   (m2p[g])
    );
  end

  // ---- s3: vc, va, vb plus delayed dots and vertices
  logic signed [VW-1:0] vv3 [3];
  logic [6*DOTW-1:0]    dot_dl [L2+1];
  logic [9*W-1:0]       vtx_dl [L1+L2+2];

  always_ff @(posedge clk) begin
    for (int v = 0; v < 3; v++) begin
      vv3[v] <= VW'(m2p[v*3]) + VW'(m2p[v*3+1]) + VW'(m2p[v*3+2]);
    end
    for (int d = 0; d < 6; d++) begin
      dot_dl[0][d*DOTW +: DOTW] <= dot2[d];
    end
    for (int k = 1; k < L2 + 1; k++) begin
      dot_dl[k] <= dot_dl[k-1];
    end
    vtx_dl[0] <= vtx1;
    for (int k = 1; k < L1 + L2 + 2; k++) begin
      vtx_dl[k] <= vtx_dl[k-1];
    end
  end

  // ---- s4: region decision and operand selection
  logic signed [DOTW-1:0] snom, sdenom, tnom, tdenom, unom, udenom;
  logic signed [VW-1:0]   vc3, va3, vb3;
  logic signed [W-1:0]    vt3 [3][3];
  cpt_pkg::region_t       rg_c;
  logic signed [NW-1:0]   den_c;
  logic signed [VW-1:0]   ex_c [3];
  logic signed [DFW-1:0]  ey_c [3][3];
  logic signed [W-1:0]    org_c [3];
  logic                   deg_c;
  logic signed [DOTW:0]   esum_ab, esum_bc, esum_ca;
  logic signed [VW+1:0]   fsum;

  assign snom   = $signed(dot_dl[L2][0*DOTW +: DOTW]);
  assign sdenom = $signed(dot_dl[L2][1*DOTW +: DOTW]);
  assign tnom   = $signed(dot_dl[L2][2*DOTW +: DOTW]);
  assign tdenom = $signed(dot_dl[L2][3*DOTW +: DOTW]);
  assign unom   = $signed(dot_dl[L2][4*DOTW +: DOTW]);
  assign udenom = $signed(dot_dl[L2][5*DOTW +: DOTW]);
  assign vc3    = vv3[0];
  assign va3    = vv3[1];
  assign vb3    = vv3[2];

  assign esum_ab = (DOTW+1)'(snom) + (DOTW+1)'(sdenom);
  assign esum_bc = (DOTW+1)'(unom) + (DOTW+1)'(udenom);
  assign esum_ca = (DOTW+1)'(tnom) + (DOTW+1)'(tdenom);
  assign fsum    = (VW+2)'(va3) + (VW+2)'(vb3) + (VW+2)'(vc3);

  always_comb begin
    for (int v = 0; v < 3; v++) begin
      for (int i = 0; i < 3; i++) begin
        vt3[v][i] = $signed(vtx_dl[L1+L2+1][(v*3+i)*W +: W]);
      end
    end
  end

  always_comb begin
    if ((snom[DOTW-1] || snom == '0) && (tnom[DOTW-1] || tnom == '0)) begin
      rg_c = cpt_pkg::RGN_VERT_A;
    end else if ((sdenom[DOTW-1] || sdenom == '0) && (unom[DOTW-1] || unom == '0)) begin
      rg_c = cpt_pkg::RGN_VERT_B;
    end else if ((tdenom[DOTW-1] || tdenom == '0) &&
                 (udenom[DOTW-1] || udenom == '0)) begin
      rg_c = cpt_pkg::RGN_VERT_C;
    end else if ((vc3[VW-1] || vc3 == '0) && !snom[DOTW-1] && !sdenom[DOTW-1]) begin
      rg_c = cpt_pkg::RGN_EDGE_AB;
    end else if ((va3[VW-1] || va3 == '0) && !unom[DOTW-1] && !udenom[DOTW-1]) begin
      rg_c = cpt_pkg::RGN_EDGE_BC;
    end else if ((vb3[VW-1] || vb3 == '0) && !tnom[DOTW-1] && !tdenom[DOTW-1]) begin
      rg_c = cpt_pkg::RGN_EDGE_CA;
    end else begin
      rg_c = cpt_pkg::RGN_FACE;
    end
  end

  // vertex regions reuse the edge path with a zero numerator
  always_comb begin
    den_c = NW'(1);
    for (int t = 0; t < 3; t++) begin
      ex_c[t] = '0;
      for (int i = 0; i < 3; i++) begin
        ey_c[t][i] = DFW'(vt3[t][i]);
      end
    end
    for (int i = 0; i < 3; i++) begin
      org_c[i] = vt3[0][i];
    end
    case (rg_c)
      cpt_pkg::RGN_VERT_A: begin
      end
      cpt_pkg::RGN_VERT_B: begin
        for (int i = 0; i < 3; i++) org_c[i] = vt3[1][i];
      end
      cpt_pkg::RGN_VERT_C: begin
        for (int i = 0; i < 3; i++) org_c[i] = vt3[2][i];
      end
      cpt_pkg::RGN_EDGE_AB: begin
        den_c   = NW'(esum_ab);
        ex_c[0] = VW'(snom);
        for (int i = 0; i < 3; i++) ey_c[0][i] = DFW'(vt3[1][i]) - DFW'(vt3[0][i]);
      end
      cpt_pkg::RGN_EDGE_BC: begin
        den_c   = NW'(esum_bc);
        ex_c[0] = VW'(unom);
        for (int i = 0; i < 3; i++) begin
          ey_c[0][i] = DFW'(vt3[2][i]) - DFW'(vt3[1][i]);
          org_c[i]   = vt3[1][i];
        end
      end
      cpt_pkg::RGN_EDGE_CA: begin
        den_c   = NW'(esum_ca);
        ex_c[0] = VW'(tnom);
        for (int i = 0; i < 3; i++) ey_c[0][i] = DFW'(vt3[2][i]) - DFW'(vt3[0][i]);
      end
      cpt_pkg::RGN_FACE: begin
        den_c   = NW'(fsum);
        ex_c[0] = va3;
        ex_c[1] = vb3;
        ex_c[2] = vc3;
        for (int i = 0; i < 3; i++) org_c[i] = '0;
      end
      default: begin
      end
    endcase
    deg_c = den_c[NW-1] || den_c == '0;
  end

  logic signed [VW-1:0]  ex4 [3];
  logic signed [DFW-1:0] ey4 [3][3];
  logic [SW-1:0]         side_dl [L3+1];

  always_ff @(posedge clk) begin
    for (int t = 0; t < 3; t++) begin
      ex4[t] <= ex_c[t];
      for (int i = 0; i < 3; i++) begin
        ey4[t][i] <= ey_c[t][i];
      end
    end
    side_dl[0][4+6*W +: NW] <= den_c;
    for (int i = 0; i < 3; i++) begin
      side_dl[0][4+3*W+i*W +: W] <= org_c[i];
      side_dl[0][4+i*W +: W]     <= vt3[0][i];
    end
    side_dl[0][3:1] <= rg_c;
    side_dl[0][0]   <= deg_c;
    for (int k = 1; k < L3 + 1; k++) begin
      side_dl[k] <= side_dl[k-1];
    end
  end

  // ---- mul level 3: weighted vertices (face) or num * direction (edge)
  logic signed [P3W-1:0] m3p [9];

  // the wide weight goes on the digit-serial side
  for (genvar g = 0; g < 9; g++) begin : g_mul3
    cpt_mul #(.AW(DFW), .BW(VW)) u_mul (
      .clk (clk),
      .a   (ey4[g/3][g%3]),
      .b   (ex4[g/3]),
      .p   (m3p[g])
    );
  end

  // ---- s5: numerators, then rounding dividers
  logic signed [NW-1:0] num5 [3];
  logic signed [NW-1:0] den5;
  logic signed [OW-1:0] qd   [3];
  logic [S2W-1:0]       tail_dl [LD+1];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      num5[i] <= NW'(m3p[i]) + NW'(m3p[3+i]) + NW'(m3p[6+i]);
    end
    den5       <= $signed(side_dl[L3][4+6*W +: NW]);
    tail_dl[0] <= side_dl[L3][S2W-1:0];
    for (int k = 1; k < LD + 1; k++) begin
      tail_dl[k] <= tail_dl[k-1];
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    cpt_div #(.NW(NW), .QB(QB)) u_div (
      .clk (clk),
      .num (num5[i]),
      .den (den5),
      .q   (qd[i])
    );
  end

  // tail_dl[LD] sits level with the divider outputs
  logic signed [OW-1:0] sum6 [3];
  logic signed [W-1:0]  sat6 [3];
  logic signed [W-1:0]  near_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum6[i] = OW'($signed(tail_dl[LD][4+3*W+i*W +: W])) + qd[i];
      if (!sum6[i][OW-1] && (|sum6[i][OW-2:W-1])) begin
        sat6[i] = {1'b0, {(W-1){1'b1}}};
      end else if (sum6[i][OW-1] && !(&sum6[i][OW-2:W-1])) begin
        sat6[i] = {1'b1, {(W-1){1'b0}}};
      end else begin
        sat6[i] = sum6[i][W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      near_q[i] <= tail_dl[LD][0] ? $signed(tail_dl[LD][4+i*W +: W]) : sat6[i];
    end
    region     <= tail_dl[LD][3:1];
    degenerate <= tail_dl[LD][0];
  end

  assign near_x = near_q[0];
  assign near_y = near_q[1];
  assign near_z = near_q[2];
  assign done   = vld[S6];

  a_deg_region: assert property (@(posedge clk) disable iff (rst)
    done && degenerate |-> region == cpt_pkg::RGN_EDGE_AB ||
      region == cpt_pkg::RGN_EDGE_BC || region == cpt_pkg::RGN_EDGE_CA ||
      region == cpt_pkg::RGN_FACE)
    else $error("degenerate result outside edge or face region");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##LAT done)
    else $error("accepted beat did not complete at fixed latency");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result without a matching accepted beat");

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for closest_point_on_triangle_top: directed and random
// triangle/query beats, predicted with exact wide integer arithmetic.
// Depends on cpt_pkg and the closest_point_on_triangle_top RTL.

typedef logic signed [31:0]  coord_t;
typedef logic signed [255:0] wide_t;
typedef wide_t  vec3_t[3];
typedef coord_t tri_query_t[12];  // ax ay az bx by bz cx cy cz qx qy qz

typedef struct {
  coord_t           nx, ny, nz;
  cpt_pkg::region_t rgn;
  logic             degen;
} near_pt_t;

class near_point_board;
  near_pt_t pending_q[$];
  int errors;
  int rgn_seen[7];
  int degen_seen;

  static function vec3_t vsub(vec3_t a, vec3_t b);
    vec3_t r;
    for (int i = 0; i < 3; i++) r[i] = a[i] - b[i];
    return r;
  endfunction

  static function wide_t vdot(vec3_t a, vec3_t b);
    return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
  endfunction

  static function vec3_t vcross(vec3_t a, vec3_t b);
    vec3_t r;
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
    return r;
  endfunction

  // nearest, ties away from zero; den > 0
  static function wide_t div_round(wide_t num, wide_t den);
    wide_t mag, q;
    mag = (num < 0) ? -num : num;
    q = (2 * mag + den) / (2 * den);
    return (num < 0) ? -q : q;
  endfunction

  static function coord_t clamp(wide_t a);
    wide_t hi, lo;
    hi = 256'sd2147483647;
    lo = -256'sd2147483648;
    if (a > hi) return coord_t'(hi);
    if (a < lo) return coord_t'(lo);
    return coord_t'(a);
  endfunction

  // origin + round(num * dir / den); returns 0 when den is not positive
  static function bit edge_pt(vec3_t org, vec3_t dir, wide_t num, wide_t den,
                              ref vec3_t q);
    if (den <= 0) return 0;
    for (int i = 0; i < 3; i++) q[i] = org[i] + div_round(num * dir[i], den);
    return 1;
  endfunction

  static function near_pt_t closest(tri_query_t it);
    vec3_t a, b, c, p, ab, ac, bc, n, ap, bp, cp, q;
    wide_t snom, sdenom, tnom, tdenom, unom, udenom, va, vb, vc, den, num;
    bit ok;
    near_pt_t r;
    for (int i = 0; i < 3; i++) begin
      a[i] = it[i]; b[i] = it[3 + i]; c[i] = it[6 + i]; p[i] = it[9 + i];
    end
    ab = vsub(b, a); ac = vsub(c, a); bc = vsub(c, b);
    q = a; ok = 1;
    snom = vdot(vsub(p, a), ab);
    sdenom = vdot(vsub(p, b), vsub(a, b));
    tnom = vdot(vsub(p, a), ac);
    tdenom = vdot(vsub(p, c), vsub(a, c));
    unom = vdot(vsub(p, b), bc);
    udenom = vdot(vsub(p, c), vsub(b, c));
    n = vcross(ab, ac);
    ap = vsub(a, p); bp = vsub(b, p); cp = vsub(c, p);
    vc = vdot(n, vcross(ap, bp));
    va = vdot(n, vcross(bp, cp));
    vb = vdot(n, vcross(cp, ap));
    if (snom <= 0 && tnom <= 0) begin
      r.rgn = cpt_pkg::RGN_VERT_A;
    end else if (sdenom <= 0 && unom <= 0) begin
      r.rgn = cpt_pkg::RGN_VERT_B; q = b;
    end else if (tdenom <= 0 && udenom <= 0) begin
      r.rgn = cpt_pkg::RGN_VERT_C; q = c;
    end else if (vc <= 0 && snom >= 0 && sdenom >= 0) begin
      r.rgn = cpt_pkg::RGN_EDGE_AB;
      ok = edge_pt(a, ab, snom, snom + sdenom, q);
    end else if (va <= 0 && unom >= 0 && udenom >= 0) begin
      r.rgn = cpt_pkg::RGN_EDGE_BC;
      ok = edge_pt(b, bc, unom, unom + udenom, q);
    end else if (vb <= 0 && tnom >= 0 && tdenom >= 0) begin
      r.rgn = cpt_pkg::RGN_EDGE_CA;
      ok = edge_pt(a, ac, tnom, tnom + tdenom, q);
    end else begin
      r.rgn = cpt_pkg::RGN_FACE;
      den = va + vb + vc;
      if (den <= 0) ok = 0;
      else for (int i = 0; i < 3; i++) begin
        num = va * a[i] + vb * b[i] + vc * c[i];
        q[i] = div_round(num, den);
      end
    end
    if (!ok) q = a;
    r.nx = clamp(q[0]); r.ny = clamp(q[1]); r.nz = clamp(q[2]);
    r.degen = !ok;
    return r;
  endfunction

  function void note_beat(tri_query_t it);
    near_pt_t e;
    e = closest(it);
    rgn_seen[e.rgn]++;
    if (e.degen) degen_seen++;
    pending_q.insert(pending_q.size(), e);
  endfunction

  function void check_result(near_pt_t got);
    near_pt_t e;
    if (pending_q.size() == 0) begin
      $display("%0t: unexpected result near=(%0d,%0d,%0d) region=%0d",
               $time, got.nx, got.ny, got.nz, got.rgn);
      errors++;
      return;
    end
    e = pending_q.pop_front();
    if (got.nx !== e.nx) begin
      $display("%0t: near_x exp %0d got %0d", $time, e.nx, got.nx); errors++;
    end
    if (got.ny !== e.ny) begin
      $display("%0t: near_y exp %0d got %0d", $time, e.ny, got.ny); errors++;
    end
    if (got.nz !== e.nz) begin
      $display("%0t: near_z exp %0d got %0d", $time, e.nz, got.nz); errors++;
    end
    if (got.rgn !== e.rgn) begin
      $display("%0t: region exp %0d got %0d", $time, e.rgn, got.rgn); errors++;
    end
    if (got.degen !== e.degen) begin
      $display("%0t: degenerate exp %0b got %0b", $time, e.degen, got.degen);
      errors++;
    end
  endfunction
endclass

module testbench;
  localparam int LATENCY = 58;
  localparam coord_t CMAX = 32'sh7fffffff;
  localparam coord_t CMIN = 32'sh80000000;
  localparam coord_t ONE  = 32'sh00010000;

  logic clk = 0, rst = 1, start = 0;
  logic busy, done, degenerate;
  coord_t fld[12];
  coord_t near_x, near_y, near_z;
  cpt_pkg::region_t region;
  near_point_board sb = new();
  near_pt_t got;

  initial for (int i = 0; i < 12; i++) fld[i] = '0;

  always #5 clk = ~clk;

  closest_point_on_triangle_top dut (
    .clk, .rst, .start, .busy,
    .vert_a_x(fld[0]), .vert_a_y(fld[1]), .vert_a_z(fld[2]),
    .vert_b_x(fld[3]), .vert_b_y(fld[4]), .vert_b_z(fld[5]),
    .vert_c_x(fld[6]), .vert_c_y(fld[7]), .vert_c_z(fld[8]),
    .query_x(fld[9]), .query_y(fld[10]), .query_z(fld[11]),
    .done, .near_x, .near_y, .near_z, .region, .degenerate
  );

  always @(posedge clk) begin
    if (!rst && done) begin
      got.nx = near_x; got.ny = near_y; got.nz = near_z;
      got.rgn = region; got.degen = degenerate;
      sb.check_result(got);
    end
  end

  task automatic send_beat(tri_query_t it, int gap);
    repeat (gap) begin
      @(negedge clk);
      start = 0;
    end
    @(negedge clk);
    fld = it;
    start = 1;
    do @(posedge clk); while (busy);
    sb.note_beat(it);
  endtask

  function automatic coord_t pick_extreme();
    case ($urandom_range(0, 5))
      0: return CMAX;
      1: return CMIN;
      2: return 0;
      3: return -1;
      4: return 1;
      default: return ONE;
    endcase
  endfunction

  // random coordinate in +/- span (Q16.16 units) around center
  function automatic coord_t near_coord(coord_t center, int span);
    return center + coord_t'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic tri_query_t rand_beat();
    tri_query_t it;
    int kind, span;
    kind = $urandom_range(0, 99);
    span = $urandom_range(0, 3) == 0 ? 32'h7fff_ffff >> $urandom_range(1, 8)
                                     : ($urandom_range(1, 8) * ONE);
    for (int i = 0; i < 12; i++) it[i] = near_coord(0, span);
    if (kind < 10) begin
      for (int i = 0; i < 12; i++) it[i] = $urandom();
    end else if (kind < 16) begin
      for (int i = 0; i < 12; i++)
        it[i] = $urandom_range(0, 1) ? pick_extreme() : coord_t'($urandom());
    end else if (kind < 24) begin
      // per component, c copies a or mirrors a through b, and b may copy a
      for (int i = 0; i < 3; i++) begin
        it[6 + i] = $urandom_range(0, 1) ? it[i] : 2 * it[3 + i] - it[i];
        if ($urandom_range(0, 2) == 0) it[3 + i] = it[i];
      end
    end else if (kind < 30) begin
      // query tiny offset from the midpoint of edge ab
      for (int i = 0; i < 3; i++)
        it[9 + i] = (it[i] >>> 1) + (it[3 + i] >>> 1) + $urandom_range(0, 4) - 2;
    end
    return it;
  endfunction

  task automatic send_directed();
    tri_query_t it;
    coord_t base[12];
    // unit right triangle in z=0, query hits each region
    base = '{0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, 0, 0};
    it = base; it[9] = -ONE; it[10] = -ONE; it[11] = ONE;    send_beat(it, 0);
    it = base; it[9] = 2 * ONE; it[10] = -ONE;               send_beat(it, 0);
    it = base; it[9] = -ONE; it[10] = 2 * ONE;               send_beat(it, 0);
    it = base; it[9] = ONE / 2; it[10] = -ONE;               send_beat(it, 0);
    it = base; it[9] = ONE; it[10] = ONE;                    send_beat(it, 0);
    it = base; it[9] = -ONE; it[10] = ONE / 3;               send_beat(it, 0);
    it = base; it[9] = ONE / 4; it[10] = ONE / 3; it[11] = 5 * ONE;
    send_beat(it, 0);
    // query on a vertex, query just off an edge
    it = base; it[9] = ONE; it[10] = 0;                      send_beat(it, 1);
    it = base; it[9] = 3; it[10] = -1;                       send_beat(it, 0);
    // all vertices equal, collinear vertices
    it = '{ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, 0, 0, 0}; send_beat(it, 0);
    it = '{0, 0, 0, ONE, ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE, 5 * ONE, 0, -ONE};
    send_beat(it, 2);
    it = '{0, 0, 0, ONE, 0, 0, 2 * ONE, 0, 0, ONE, ONE, 0}; send_beat(it, 0);
    // extremes of the range, saturating results
    it = '{CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN, 0, 0, 0, 0};
    send_beat(it, 0);
    it = '{CMIN, CMAX, 0, CMAX, CMIN, 0, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN};
    send_beat(it, 0);
    it = '{CMAX, 0, 0, 0, CMAX, 0, 0, 0, CMAX, CMIN, CMIN, CMIN}; send_beat(it, 3);
    it = '{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX};
    send_beat(it, 0);
    for (int i = 0; i < 12; i++) it[i] = -1;                 send_beat(it, 0);
    for (int i = 0; i < 12; i++) it[i] = 0;                  send_beat(it, 0);
    it = '{0, 0, 0, CMAX, 0, 0, 0, CMAX, 0, CMAX, CMAX, CMAX}; send_beat(it, 0);
    it = '{0, 0, 0, CMIN, 0, 0, 0, CMIN, 0, CMAX / 4, CMAX / 4, CMAX};
    send_beat(it, 0);
  endtask

  initial begin
    int gap;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 0;
    send_directed();
    for (int n = 0; n < 1350; n++) begin
      gap = ($urandom_range(0, 3) == 0 || (n / 200) % 2 == 1) ? 0
                                                              : $urandom_range(0, 12);
      if (n == 600) begin
        // drain the pipeline before carrying on
        @(negedge clk);
        start = 0;
        while (sb.pending_q.size() != 0) @(posedge clk);
      end
      send_beat(rand_beat(), gap);
    end
    @(negedge clk);
    start = 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    $display("Covered regions a/b/c/ab/bc/ca/face: %0d %0d %0d %0d %0d %0d %0d",
             sb.rgn_seen[0], sb.rgn_seen[1], sb.rgn_seen[2], sb.rgn_seen[3],
             sb.rgn_seen[4], sb.rgn_seen[5], sb.rgn_seen[6]);
    $display("Degenerate beats: %0d, checking errors: %0d", sb.degen_seen, sb.errors);
    if (sb.errors == 0 && sb.pending_q.size() == 0)
      $display("[closest_point_on_triangle_top] OK");
    else
      $display("[closest_point_on_triangle_top] ERROR");
    $finish;
  end

  initial begin
    #5ms;
    $display("%0t: timeout", $time);
    $display("[closest_point_on_triangle_top] ERROR");
    $finish;
  end
endmodule
